FILE: rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// Fermentation stage classifier package
// Shared types, constants and sequencer states.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int TREND_WINDOW_DEF = 6;

  localparam int GW = 14;
  localparam int CW = 16;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_G,
    ST_DIV_C,
    ST_SCORE,
    ST_OUT
  } fsc_state_t;

  // Stage codes.
  localparam logic [2:0] STAGE_LAG      = 3'd0;
  localparam logic [2:0] STAGE_ACTIVE   = 3'd1;
  localparam logic [2:0] STAGE_PEAK     = 3'd2;
  localparam logic [2:0] STAGE_SLOWING  = 3'd3;
  localparam logic [2:0] STAGE_FINISHED = 3'd4;
  localparam logic [2:0] STAGE_STUCK    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_STUCK    = 2'd1;
  localparam logic [1:0] REG_DELTA    = 2'd2;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [23:0] dividend_mag;
    logic        neg;
  } fsc_div_req_t;

  // The signed quotient needs one bit above the 24-bit magnitude.
  typedef struct packed {
    logic        done;
    logic [24:0] quot;
  } fsc_div_rsp_t;

endpackage

FILE: rtl/core/fsc_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, signed truncation.
// ----------------------------------------------------------------------------
module fsc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fsc_pkg::fsc_div_req_t req,
  input  logic [7:0]            divisor,
  output fsc_pkg::fsc_div_rsp_t rsp
);

  logic [23:0] quo_r, quo_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  trial;

  // One quotient bit per step.
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r[7:0], quo_r[23]};
    if (req.start) begin
      quo_nxt  = req.dividend_mag;
      rem_nxt  = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (~{1'b0, quo_r} + 25'd1) : {1'b0, quo_r};

  // The remainder stays below the divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 5'd0 |-> rem_r < {1'b0, divisor})
    else $error("divider remainder out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 5'd23)
    else $error("divider count overrun");

endmodule

FILE: rtl/core/fermentation_stage_classifier.sv
// An accepted request runs through ST_DIV_G and ST_DIV_C, two 24-step passes
// of the shared serial divider (skipped on the first sample), then ST_SCORE,
// and out_tvalid rises in ST_OUT.
// A new sample is not taken before the result is: in_tready is low
// from acceptance until the result is taken.
// Reset (rst_n, synchronous, active low) restores the registers to
// interval 1, stuck 48 h, delta 10, and clears the history and stage.
// ----------------------------------------------------------------------------
// Fermentation stage classifier
// Tracks gravity and CO2 history and classifies the fermentation stage.
// ----------------------------------------------------------------------------
module fermentation_stage_classifier #(
  parameter int TREND_WINDOW = fsc_pkg::TREND_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // gravity[13:0], co2_ppm[29:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // stage[2:0], activity[13:3], trend[16:14]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int HALF = TREND_WINDOW / 2;
  localparam int SW   = fsc_pkg::GW + $clog2(HALF + 1) + 2;
  localparam int CNTW = $clog2(TREND_WINDOW + 1);

  // Reciprocals for the constant divisions, rounded up.
  localparam logic [15:0] RECIP_25_K20 = 16'd41944;
  localparam logic [15:0] RECIP_33_K20 = 16'd31776;
  localparam logic [15:0] RECIP_33_K21 = 16'd63551;

  // Configuration registers.
  logic [7:0] interval_r;
  logic [7:0] stuck_r;
  logic [9:0] delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 8'd1;
      stuck_r    <= 8'd48;
      delta_r    <= 10'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fsc_pkg::REG_INTERVAL: interval_r <= cfg_data[7:0];
        fsc_pkg::REG_STUCK:    stuck_r    <= cfg_data[7:0];
        fsc_pkg::REG_DELTA:    delta_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [7:0] iv;
  assign iv = (interval_r == 8'd0) ? 8'd1 : interval_r;

  // State.
  fsc_pkg::fsc_state_t state_r, state_nxt;
  logic [fsc_pkg::GW-1:0] win_r [TREND_WINDOW];
  logic [fsc_pkg::CW-1:0] pco2_r;
  logic [CNTW-1:0]        cnt_r;
  logic [15:0]            run_r;
  logic signed [24:0]     gslope_r;
  logic signed [23:0]     cslope_r;
  logic signed [2:0]      trend_r;
  logic [2:0]             stage_r;
  logic [10:0]            act_r;
  logic [fsc_pkg::GW-1:0] g_r;
  logic [fsc_pkg::CW-1:0] co2_r;
  logic signed [16:0]     dc_r;
  logic                   rate_r;

  fsc_pkg::fsc_div_req_t dreq;
  fsc_pkg::fsc_div_rsp_t drsp;

  fsc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .divisor(iv), .rsp(drsp));

  logic in_acc;
  assign in_tready = (state_r == fsc_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Dividend magnitudes for the two rates.
  logic [16:0] adc;
  logic signed [14:0] d_in;
  logic signed [16:0] dc_in;
  assign d_in  = $signed({1'b0, win_r[0]}) - $signed({1'b0, in_tdata[13:0]});
  assign dc_in = $signed({1'b0, in_tdata[29:14]}) - $signed({1'b0, pco2_r});
  assign adc   = dc_r[16] ? 17'(-dc_r) : 17'(dc_r);

  always_comb begin
    dreq = '0;
    if (state_r == fsc_pkg::ST_IDLE && in_acc && cnt_r != '0) begin
      dreq.start        = 1'b1;
      dreq.neg          = d_in[14];
      dreq.dividend_mag = 24'(d_in[14] ? 15'(-d_in) : 15'(d_in)) * 24'd600;
    end else if (state_r == fsc_pkg::ST_DIV_G && drsp.done) begin
      dreq.start        = 1'b1;
      dreq.neg          = dc_r[16];
      dreq.dividend_mag = 24'(adc) * 24'd60;
    end
  end

  // Trend sums over the window after the shift.
  logic [SW-1:0] recent, older;
  logic signed [SW:0] diff;
  always_comb begin
    recent = '0;
    older  = '0;
    for (int i = 0; i < HALF; i++) begin
      recent = recent + SW'(win_r[i]);
      older  = older + SW'(win_r[i + HALF]);
    end
    diff = $signed({1'b0, older}) - $signed({1'b0, recent});
  end

  // Scores. Each score saturates at a known input, so only the range below
  // that point is divided, by a reciprocal multiply that is exact there.
  // A CO2 rate score below -1120 already drives the sum to zero.
  logic [24:0] ag;
  logic [23:0] cm;
  logic [29:0] p1, p2;
  logic [15:0] x3;
  logic [31:0] p3;
  logic [10:0] q3;
  logic [10:0] s1, s2;
  logic signed [12:0] s3;
  logic signed [13:0] act_sum;
  logic [10:0] act;
  logic [23:0] stable_min;
  always_comb begin
    ag = gslope_r[24] ? 25'(-gslope_r) : 25'(gslope_r);
    cm = cslope_r[23] ? 24'(-cslope_r) : 24'(cslope_r);
    p1 = 30'({ag[10:0], 3'b000}) * 30'(RECIP_25_K20);
    s1 = (ag < 25'd2000) ? {1'b0, p1[29:20]} : 11'd640;
    p2 = 30'({co2_r[9:0], 4'b0000}) * 30'(RECIP_33_K20);
    s2 = (co2_r < 16'd990) ? {1'b0, p2[29:20]} : 11'd480;
    x3 = 16'({8'd0, cm[7:0]}) * 16'd160;
    p3 = 32'(x3) * 32'(RECIP_33_K21);
    q3 = p3[31:21];
    if (!cslope_r[23]) begin
      s3 = (cm < 24'd99) ? $signed({2'b00, q3}) : 13'sd480;
    end else begin
      s3 = (cm < 24'd232) ? -$signed({2'b00, q3}) : -13'sd1121;
    end
    act_sum = $signed({3'b0, s1}) + $signed({3'b0, s2}) + 14'(s3);
    if (act_sum < 0) act = 11'd0;
    else if (act_sum > 14'sd1600) act = 11'd1600;
    else act = act_sum[10:0];
    stable_min = 24'(run_r) * 24'(iv);
  end

  logic [2:0] stage_new;
  always_comb begin
    stage_new = stage_r;
    priority if (g_r > 14'd10600 && act < 11'd240 && co2_r < 16'd600)
      stage_new = fsc_pkg::STAGE_LAG;
    else if (gslope_r > 25'sd100 && co2_r > 16'd500)
      stage_new = fsc_pkg::STAGE_ACTIVE;
    else if (act >= 11'd1440 && g_r > 14'd10200 && g_r < 14'd10400)
      stage_new = fsc_pkg::STAGE_PEAK;
    else if (gslope_r > 25'sd0 && gslope_r < 25'sd200 && co2_r > 16'd200)
      stage_new = fsc_pkg::STAGE_SLOWING;
    else if (g_r < 14'd10150 && stable_min > 24'd1440 && co2_r < 16'd100)
      stage_new = fsc_pkg::STAGE_FINISHED;
    else if (stable_min > 24'(stuck_r) * 24'd60 && act < 11'd80)
      stage_new = fsc_pkg::STAGE_STUCK;
    else
      stage_new = stage_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsc_pkg::ST_IDLE:  if (in_acc) state_nxt = (cnt_r != '0) ? fsc_pkg::ST_DIV_G
                                                             : fsc_pkg::ST_SCORE;
      fsc_pkg::ST_DIV_G: if (drsp.done) state_nxt = fsc_pkg::ST_DIV_C;
      fsc_pkg::ST_DIV_C: if (drsp.done) state_nxt = fsc_pkg::ST_SCORE;
      fsc_pkg::ST_SCORE: state_nxt = fsc_pkg::ST_OUT;
      fsc_pkg::ST_OUT:   if (out_tready) state_nxt = fsc_pkg::ST_IDLE;
      default:           state_nxt = fsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fsc_pkg::ST_IDLE;
      pco2_r   <= '0;
      cnt_r    <= '0;
      run_r    <= '0;
      gslope_r <= '0;
      cslope_r <= '0;
      trend_r  <= '0;
      stage_r  <= fsc_pkg::STAGE_LAG;
      rate_r   <= 1'b0;
      for (int i = 0; i < TREND_WINDOW; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        win_r[0] <= in_tdata[13:0];
        for (int i = 1; i < TREND_WINDOW; i++) win_r[i] <= win_r[i-1];
        pco2_r <= in_tdata[29:14];
        rate_r <= (cnt_r != '0);
        if (cnt_r != CNTW'(TREND_WINDOW)) cnt_r <= cnt_r + 1'b1;
        if (cnt_r != '0) begin
          if ((d_in[14] ? 15'(-d_in) : 15'(d_in)) < {5'd0, delta_r}) begin
            if (run_r != 16'hFFFF) run_r <= run_r + 16'd1;
          end else begin
            run_r <= '0;
          end
        end
      end
      if (state_r == fsc_pkg::ST_DIV_G && drsp.done) gslope_r <= signed'(drsp.quot);
      if (state_r == fsc_pkg::ST_DIV_C && drsp.done) cslope_r <= signed'(drsp.quot[23:0]);
      if (state_r == fsc_pkg::ST_SCORE) begin
        stage_r <= stage_new;
        act_r   <= act;
        if (cnt_r == CNTW'(TREND_WINDOW)) begin
          if (diff > (SW+1)'(50 * HALF))       trend_r <= -3'sd2;
          else if (diff > (SW+1)'(20 * HALF))  trend_r <= -3'sd1;
          else if (diff > -(SW+1)'(20 * HALF)) trend_r <= 3'sd0;
          else if (diff > -(SW+1)'(50 * HALF)) trend_r <= 3'sd1;
          else                                 trend_r <= 3'sd2;
        end
      end
    end
    if (in_acc) begin
      g_r   <= in_tdata[13:0];
      co2_r <= in_tdata[29:14];
      dc_r  <= dc_in;
    end
  end

  assign out_tvalid = (state_r == fsc_pkg::ST_OUT);
  assign out_tdata  = {7'd0, trend_r, act_r, stage_r};

  // Rates are computed only when a previous sample existed.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fsc_pkg::ST_DIV_G |-> rate_r)
    else $error("rate computed on first sample");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> act_r <= 11'd1600 && stage_r <= fsc_pkg::STAGE_STUCK)
    else $error("result out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != fsc_pkg::ST_IDLE |-> !in_tready)
    else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(TREND_WINDOW))
    else $error("sample count overflow");

endmodule
